@@ hdl/tlpt_pkg.sv @@
// Shared types and constants of the two-level page table engine.
// Used by tlpt_table_store and two_level_page_table_engine; depends on nothing.
`timescale 1ns / 1ps

package tlpt_pkg;

    localparam int TABLE_POOL        = 32;
    localparam int ENTRIES_PER_TABLE = 1024;
    localparam int DIR_SLOTS         = 1024;

    localparam int ADDR_W     = 32;
    localparam int FLAGS_W    = 12;
    localparam int PAGE_SHIFT = 12;
    localparam int DIR_SHIFT  = 22;
    localparam int DIR_IDX_W  = $clog2(DIR_SLOTS);
    localparam int IDX_W      = $clog2(ENTRIES_PER_TABLE);
    localparam int TBL_IDX_W  = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
    localparam int CNT_W      = $clog2(TABLE_POOL + 1);
    localparam int TADDR_W    = TBL_IDX_W + IDX_W;
    localparam int TBL_DEPTH  = TABLE_POOL * ENTRIES_PER_TABLE;

    localparam int FLAG_PRESENT = 0;
    localparam int FLAG_WRITE   = 1;
    localparam int FLAG_USER    = 2;

    typedef enum logic [1:0] {
        OP_MAP       = 2'd0,
        OP_UNMAP     = 2'd1,
        OP_TRANSLATE = 2'd2,
        OP_CHECK     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_MAPPED = 2'd1,
        ST_NO_TABLE   = 2'd2
    } t_status;

    typedef struct packed {
        logic                 present;
        logic                 writable;
        logic                 user;
        logic [TBL_IDX_W-1:0] tbl;
    } t_dir_entry;

    // Command from the sequencer to the table store.
    typedef struct packed {
        logic               rd_en;
        logic               wr_en;
        logic               clr_start;
        logic [TADDR_W-1:0] addr;
        logic [ADDR_W-1:0]  wdata;
    } t_tbl_cmd;

endpackage

@@ hdl/tlpt_table_store.sv @@
// Page table entry memory with a registered read port and the sweep that
// clears a freshly allocated table. Depends on tlpt_pkg.
`timescale 1ns / 1ps

module tlpt_table_store (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tlpt_pkg::t_tbl_cmd         i_cmd,
    output logic [tlpt_pkg::ADDR_W-1:0] o_rdata,
    output logic                       o_clr_done
);
    import tlpt_pkg::*;

    logic [ADDR_W-1:0]    mem [TBL_DEPTH];
    logic [ADDR_W-1:0]    r_rdata;

    logic                 r_clr_active;
    logic [IDX_W-1:0]     r_clr_idx;
    logic [TBL_IDX_W-1:0] r_clr_tbl;
    logic [IDX_W-1:0]     r_clr_tgt;
    logic [ADDR_W-1:0]    r_clr_entry;

    logic                 wr_en;
    logic [TADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]    wr_data;
    logic                 clr_last;

    assign clr_last = r_clr_active && (r_clr_idx == IDX_W'(ENTRIES_PER_TABLE - 1));

    // The sweep zeroes every entry of the new table and drops the new mapping
    // in on its way past, so the entry needs no separate write.
    always_comb begin
        if (r_clr_active) begin
            wr_en   = 1'b1;
            wr_addr = {r_clr_tbl, r_clr_idx};
            wr_data = (r_clr_idx == r_clr_tgt) ? r_clr_entry : '0;
        end else begin
            wr_en   = i_cmd.wr_en;
            wr_addr = i_cmd.addr;
            wr_data = i_cmd.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[i_cmd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b0;
            r_clr_idx    <= '0;
        end else if (i_cmd.clr_start) begin
            r_clr_active <= 1'b1;
            r_clr_idx    <= '0;
        end else if (r_clr_active) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (clr_last) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_start) begin
            r_clr_tbl   <= i_cmd.addr[IDX_W +: TBL_IDX_W];
            r_clr_tgt   <= i_cmd.addr[IDX_W-1:0];
            r_clr_entry <= i_cmd.wdata;
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clr_done = clr_last;

endmodule

@@ hdl/two_level_page_table_engine.sv @@
// Top level of the two-level page table engine: request sequencer, page
// directory memory and output register. Depends on tlpt_pkg and tlpt_table_store.
`timescale 1ns / 1ps

// The engine holds one page directory of 1024 slots and a pool of page tables
// of 1024 entries each, both in single-port synchronous memories, and takes one
// request at a time. After reset the directory is cleared one slot per cycle,
// so no request is accepted until every slot is cleared. A translate, unmap or
// user check reads the directory slot and then the page entry. A map into a
// present slot, and any request that misses in the directory, finishes after
// the directory read. A map that allocates a new table clears its 1024 entries
// one per cycle. A new request is accepted while a result still waits in the
// output register.
module two_level_page_table_engine (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_op,
    input  logic [tlpt_pkg::ADDR_W-1:0]  i_vaddr,
    input  logic [tlpt_pkg::ADDR_W-1:0]  i_paddr,
    input  logic [tlpt_pkg::FLAGS_W-1:0] i_page_flags,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_status,
    output logic [tlpt_pkg::ADDR_W-1:0]  o_phys_out,
    output logic                         o_user_ok
);
    import tlpt_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DIR,
        S_TBL,
        S_FILL,
        S_WAIT
    } t_state;

    t_state               r_state, n_state;
    logic [DIR_IDX_W-1:0] r_init_idx, n_init_idx;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    t_op                  r_op, n_op;
    logic [ADDR_W-1:0]    r_vaddr, n_vaddr;
    logic [ADDR_W-1:0]    r_paddr, n_paddr;
    logic [FLAGS_W-1:0]   r_flags, n_flags;

    t_status              r_res_status, n_res_status;
    logic [ADDR_W-1:0]    r_res_phys, n_res_phys;
    logic                 r_res_user, n_res_user;

    logic                 r_out_valid, n_out_valid;
    t_status              r_out_status, n_out_status;
    logic [ADDR_W-1:0]    r_out_phys, n_out_phys;
    logic                 r_out_user, n_out_user;

    t_dir_entry           dir_mem [DIR_SLOTS];
    t_dir_entry           r_dir;
    logic                 dir_rd_en;
    logic                 dir_we;
    logic [DIR_IDX_W-1:0] dir_waddr;
    t_dir_entry           dir_wdata;

    t_tbl_cmd             tbl_cmd;
    logic [ADDR_W-1:0]    tbl_rdata;
    logic                 clr_done;

    logic                 out_free;
    logic                 finish;
    t_status              fin_status;
    logic [ADDR_W-1:0]    fin_phys;
    logic                 fin_user;
    logic [DIR_IDX_W-1:0] dir_idx;
    logic [IDX_W-1:0]     pte_idx;
    logic [ADDR_W-1:0]    new_entry;

    tlpt_table_store u_table_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (tbl_cmd),
        .o_rdata    (tbl_rdata),
        .o_clr_done (clr_done)
    );

    assign dir_idx   = r_vaddr[DIR_SHIFT +: DIR_IDX_W];
    assign pte_idx   = r_vaddr[PAGE_SHIFT +: IDX_W];
    assign new_entry = {r_paddr[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}}
                     | {{(ADDR_W - FLAGS_W){1'b0}}, r_flags}
                     | ADDR_W'(1 << FLAG_PRESENT);
    assign out_free  = !r_out_valid || i_out_ready;
    assign dir_rd_en = (r_state == S_IDLE) && i_in_valid;

    always_comb begin
        n_state      = r_state;
        n_init_idx   = r_init_idx;
        n_cnt        = r_cnt;
        n_op         = r_op;
        n_vaddr      = r_vaddr;
        n_paddr      = r_paddr;
        n_flags      = r_flags;
        n_res_status = r_res_status;
        n_res_phys   = r_res_phys;
        n_res_user   = r_res_user;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_phys   = r_out_phys;
        n_out_user   = r_out_user;

        dir_we    = 1'b0;
        dir_waddr = dir_idx;
        dir_wdata = r_dir;
        tbl_cmd   = '0;
        tbl_cmd.addr = {r_dir.tbl, pte_idx};

        finish     = 1'b0;
        fin_status = ST_OK;
        fin_phys   = '0;
        fin_user   = 1'b0;

        unique case (r_state)
            S_INIT: begin
                dir_we     = 1'b1;
                dir_waddr  = r_init_idx;
                dir_wdata  = '0;
                n_init_idx = r_init_idx + 1'b1;
                if (r_init_idx == DIR_IDX_W'(DIR_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = t_op'(i_op);
                    n_vaddr = i_vaddr;
                    n_paddr = i_paddr;
                    n_flags = i_page_flags;
                    n_state = S_DIR;
                end
            end
            S_DIR: begin
                if (r_op == OP_MAP) begin
                    if (r_dir.present) begin
                        tbl_cmd.wr_en = 1'b1;
                        tbl_cmd.wdata = new_entry;
                        if (r_flags[FLAG_USER]) begin
                            dir_we         = 1'b1;
                            dir_wdata.user = 1'b1;
                        end
                        finish = 1'b1;
                    end else if (r_cnt >= CNT_W'(TABLE_POOL)) begin
                        fin_status = ST_NO_TABLE;
                        finish     = 1'b1;
                    end else begin
                        dir_we             = 1'b1;
                        dir_wdata.present  = 1'b1;
                        dir_wdata.writable = 1'b1;
                        dir_wdata.user     = r_flags[FLAG_USER];
                        dir_wdata.tbl      = TBL_IDX_W'(r_cnt);
                        n_cnt              = r_cnt + 1'b1;
                        tbl_cmd.clr_start  = 1'b1;
                        tbl_cmd.addr       = {TBL_IDX_W'(r_cnt), pte_idx};
                        tbl_cmd.wdata      = new_entry;
                        n_state            = S_FILL;
                    end
                end else if (!r_dir.present) begin
                    fin_status = ST_NOT_MAPPED;
                    finish     = 1'b1;
                end else begin
                    tbl_cmd.rd_en = 1'b1;
                    n_state       = S_TBL;
                end
            end
            S_TBL: begin
                finish = 1'b1;
                if (!tbl_rdata[FLAG_PRESENT]) begin
                    fin_status = ST_NOT_MAPPED;
                end else begin
                    case (r_op)
                        OP_UNMAP: begin
                            tbl_cmd.wr_en = 1'b1;
                            tbl_cmd.wdata = '0;
                        end
                        OP_TRANSLATE: begin
                            fin_phys = {tbl_rdata[ADDR_W-1:PAGE_SHIFT],
                                        r_vaddr[PAGE_SHIFT-1:0]};
                        end
                        default: begin
                            fin_user = r_dir.user && tbl_rdata[FLAG_USER];
                        end
                    endcase
                end
            end
            S_FILL: begin
                if (clr_done) begin
                    finish = 1'b1;
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_phys   = r_res_phys;
                    n_out_user   = r_res_user;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase

        // A finished result goes straight to the output register when it is
        // free, and otherwise parks until the previous one is taken.
        if (finish) begin
            if (out_free) begin
                n_out_valid  = 1'b1;
                n_out_status = fin_status;
                n_out_phys   = fin_phys;
                n_out_user   = fin_user;
                n_state      = S_IDLE;
            end else begin
                n_res_status = fin_status;
                n_res_phys   = fin_phys;
                n_res_user   = fin_user;
                n_state      = S_WAIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_idx  <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init_idx  <= n_init_idx;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_op         <= n_op;
        r_vaddr      <= n_vaddr;
        r_paddr      <= n_paddr;
        r_flags      <= n_flags;
        r_res_status <= n_res_status;
        r_res_phys   <= n_res_phys;
        r_res_user   <= n_res_user;
        r_out_status <= n_out_status;
        r_out_phys   <= n_out_phys;
        r_out_user   <= n_out_user;
    end

    always_ff @(posedge i_clk) begin
        if (dir_we) begin
            dir_mem[dir_waddr] <= dir_wdata;
        end
        if (dir_rd_en) begin
            r_dir <= dir_mem[i_vaddr[DIR_SHIFT +: DIR_IDX_W]];
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_phys_out  = r_out_phys;
    assign o_user_ok   = r_out_user;

endmodule

@@ verif/tb_page_walk_pkg.sv @@
// Scoreboard for the two-level page table engine testbench: a predictor of the
// directory and the table pool, and the queue of results still to arrive. Depends on tlpt_pkg.
`timescale 1ns / 1ps

package page_walk_tb_pkg;

    import tlpt_pkg::*;

    typedef struct {
        t_status     status;
        logic [31:0] phys;
        logic        user_ok;
    } t_walk_result;

    class page_walk_scoreboard;
        bit        slot_present [DIR_SLOTS];
        bit        slot_user    [DIR_SLOTS];
        int        slot_table   [DIR_SLOTS];
        bit [31:0] shadow_ptes  [TBL_DEPTH];
        int        tables_taken;
        int        errors;
        t_walk_result pending_results[$];

        // Applies one accepted request to the shadow tables and queues its result.
        function void note_request(t_op op, logic [31:0] vaddr, logic [31:0] paddr,
                                   logic [11:0] flags);
            int           dir;
            int           pos;
            bit [31:0]    entry;
            t_walk_result res;
            dir = vaddr[31:22];
            res = '{status: ST_OK, phys: '0, user_ok: 1'b0};
            if (op == OP_MAP) begin
                if (!slot_present[dir]) begin
                    if (tables_taken >= TABLE_POOL) begin
                        res.status = ST_NO_TABLE;
                    end else begin
                        for (int k = 0; k < ENTRIES_PER_TABLE; k++)
                            shadow_ptes[tables_taken * ENTRIES_PER_TABLE + k] = '0;
                        slot_present[dir] = 1'b1;
                        slot_user[dir]    = 1'b0;
                        slot_table[dir]   = tables_taken;
                        tables_taken++;
                    end
                end
                if (res.status == ST_OK) begin
                    if (flags[FLAG_USER])
                        slot_user[dir] = 1'b1;
                    pos = slot_table[dir] * ENTRIES_PER_TABLE + vaddr[21:12];
                    shadow_ptes[pos] = {paddr[31:12], 12'h000} | {20'h0, flags} | 32'h1;
                end
            end else begin
                entry = '0;
                pos   = slot_table[dir] * ENTRIES_PER_TABLE + vaddr[21:12];
                if (slot_present[dir])
                    entry = shadow_ptes[pos];
                if (!entry[FLAG_PRESENT]) begin
                    res.status = ST_NOT_MAPPED;
                end else if (op == OP_UNMAP) begin
                    shadow_ptes[pos] = '0;
                end else if (op == OP_TRANSLATE) begin
                    res.phys = {entry[31:12], vaddr[11:0]};
                end else begin
                    res.user_ok = slot_user[dir] && entry[FLAG_USER];
                end
            end
            pending_results.push_back(res);
        endfunction

        function void check_response(logic [1:0] status, logic [31:0] phys, logic user_ok);
            t_walk_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: result with none outstanding: status %0d phys %h user_ok %b",
                         $time, status, phys, user_ok);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                errors++;
            end
            if (phys !== want.phys) begin
                $display("%0t: phys_out expected %h actual %h", $time, want.phys, phys);
                errors++;
            end
            if (user_ok !== want.user_ok) begin
                $display("%0t: user_ok expected %b actual %b", $time, want.user_ok, user_ok);
                errors++;
            end
        endfunction
    endclass

endpackage

@@ verif/tb_two_level_page_table_engine.sv @@
// Top of the two-level page table engine testbench: clock, reset, request driver,
// result receiver and monitor. Depends on tlpt_pkg, page_walk_tb_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb_two_level_page_table_engine;

    import tlpt_pkg::*;
    import page_walk_tb_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_op = '0;
    logic [31:0] i_vaddr = '0;
    logic [31:0] i_paddr = '0;
    logic [11:0] i_page_flags = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_phys_out;
    logic        o_user_ok;

    logic        recv_hold = 1'b0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic [31:0] known_pages[$];

    page_walk_scoreboard sb = new();

    two_level_page_table_engine i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_vaddr      (i_vaddr),
        .i_paddr      (i_paddr),
        .i_page_flags (i_page_flags),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_phys_out   (o_phys_out),
        .o_user_ok    (o_user_ok)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            sb.note_request(t_op'(i_op), i_vaddr, i_paddr, i_page_flags);
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_response(o_status, o_phys_out, o_user_ok);
    end

    // Valid stays high from one request to the next unless an idle gap is taken.
    task automatic send_request(t_op op, logic [31:0] vaddr, logic [31:0] paddr,
                                logic [11:0] flags);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_vaddr      <= vaddr;
        i_paddr      <= paddr;
        i_page_flags <= flags;
        do @(posedge i_clk); while (!o_in_ready);
        if (op == OP_MAP) begin
            known_pages.push_back(vaddr);
            if (known_pages.size() > 64)
                void'(known_pages.pop_front());
        end
    endtask

    // Most requests reuse pages already mapped so that lookups hit; a share of
    // maps go to fresh directory slots, so the table pool runs dry.
    task automatic send_random_request(bit lookups_only);
        int          pick;
        t_op         op;
        logic [31:0] vaddr;
        logic [31:0] seen;
        pick  = $urandom_range(99);
        op    = (pick < 32) ? OP_MAP : (pick < 47) ? OP_UNMAP :
                (pick < 75) ? OP_TRANSLATE : OP_CHECK;
        if (lookups_only)
            op = pick[0] ? OP_TRANSLATE : OP_CHECK;
        vaddr = $urandom;
        if (known_pages.size() > 0) begin
            seen = known_pages[$urandom_range(known_pages.size() - 1)];
            pick = $urandom_range(99);
            if (op == OP_MAP) begin
                if (pick < 40)
                    vaddr[31:12] = seen[31:12];
                else if (pick < 65)
                    vaddr[31:22] = seen[31:22];
            end else if (pick < 80) begin
                vaddr[31:12] = seen[31:12];
            end
        end
        send_request(op, vaddr, $urandom, 12'($urandom_range(4095)));
    endtask

    task automatic hold_receiver(int cycles);
        recv_hold <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        recv_hold <= 1'b0;
    endtask

    initial begin
        int send_plan[4];
        int recv_plan[4];
        send_plan = '{0, 76, 0, 23};
        recv_plan = '{0, 0, 76, 23};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Misses on an empty directory.
        send_request(OP_TRANSLATE, 32'h0000_0000, 32'h0, 12'h000);
        send_request(OP_UNMAP,     32'hFFFF_FFFF, 32'h0, 12'h000);
        send_request(OP_CHECK,     32'h1234_5678, 32'h0, 12'h000);
        // First map allocates a table; all flag bits set, including user.
        send_request(OP_MAP,       32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
        send_request(OP_TRANSLATE, 32'h0000_0FFF, 32'h0, 12'h000);
        send_request(OP_CHECK,     32'h0000_0000, 32'h0, 12'h000);
        // Present slot, but the entry was never written.
        send_request(OP_TRANSLATE, 32'h0000_1000, 32'h0, 12'h000);
        // Last slot with no flags: the entry still comes out present.
        send_request(OP_MAP,       32'hFFFF_FFFF, 32'h0000_0000, 12'h000);
        send_request(OP_CHECK,     32'hFFFF_F000, 32'h0, 12'h000);
        send_request(OP_TRANSLATE, 32'hFFFF_FABC, 32'h0, 12'h000);
        // A user map into a present slot promotes the slot to user.
        send_request(OP_MAP,       32'hFFC0_1000, 32'h5A5A_5000, 12'h004);
        send_request(OP_CHECK,     32'hFFC0_1000, 32'h0, 12'h000);
        send_request(OP_CHECK,     32'hFFFF_F000, 32'h0, 12'h000);
        send_request(OP_MAP,       32'h0040_0000, 32'hA5A5_A5A5, 12'h000);
        send_request(OP_MAP,       32'h0040_1000, 32'h1234_5FFF, 12'h004);
        // Unmap, then miss on the same page, then remap without a new table.
        send_request(OP_UNMAP,     32'h0000_0123, 32'h0, 12'h000);
        send_request(OP_TRANSLATE, 32'h0000_0000, 32'h0, 12'h000);
        send_request(OP_UNMAP,     32'h0000_0000, 32'h0, 12'h000);
        send_request(OP_MAP,       32'h0000_0000, 32'h8000_0000, 12'h002);
        send_request(OP_TRANSLATE, 32'h0000_0555, 32'h0, 12'h000);
        send_request(OP_CHECK,     32'h0000_0000, 32'h0, 12'h000);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_plan[ph];
            recv_stall_pct = recv_plan[ph];
            repeat (120) send_random_request(1'b0);
            if (ph == 0) begin
                // Hold the result side off long enough for the input to back up.
                fork
                    hold_receiver(300);
                join_none
                repeat (30) send_random_request(1'b1);
            end
        end
        i_in_valid <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #12_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/tlpt_pkg.sv
hdl/tlpt_table_store.sv
hdl/two_level_page_table_engine.sv
verif/tb_page_walk_pkg.sv
verif/tb_two_level_page_table_engine.sv
